// File: hw/rtl/htw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer wheel package
// Shared sizes, codes, command type and bucket selection for the timer wheel.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int MAX_TIMERS = 64;
  localparam int ID_W       = 6;
  localparam int LINK_W     = ID_W + 1;            // top bit marks an empty link
  localparam logic [LINK_W-1:0] NIL = {1'b1, {ID_W{1'b0}}};
  localparam int TICK_W     = 32;
  localparam int CNT_W      = 7;
  localparam int ROOT_BITS  = 8;
  localparam int LEVEL_BITS = 6;
  localparam int LEVELS     = 5;
  localparam int LVL_NUM    = LEVELS - 1;
  localparam int LVL_W      = $clog2(LVL_NUM);
  localparam int ROOT_SIZE  = 1 << ROOT_BITS;
  localparam int LVL_SIZE   = 1 << LEVEL_BITS;
  localparam int NBUCKETS   = ROOT_SIZE + LVL_NUM * LVL_SIZE;
  localparam int BKT_AW     = $clog2(NBUCKETS);
  localparam int OP_W       = 2;
  localparam int KIND_W     = 3;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 48;

  typedef enum logic [OP_W-1:0] {
    OP_ARM_ONE = 2'd0,
    OP_ARM_PER = 2'd1,
    OP_CANCEL  = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_ARM,
    CMD_REFUSE,
    CMD_CANCEL,
    CMD_TICK
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    K_ARMED       = 3'd0,
    K_REFUSED     = 3'd1,
    K_CANCELLED   = 3'd2,
    K_CANCEL_IDLE = 3'd3,
    K_EXPIRED     = 3'd4,
    K_IDLE_TICK   = 3'd5
  } kind_e;

  typedef struct packed {
    cmd_e              cmd;
    logic              per;
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] timeout;
  } cmd_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_ARM_LINK, ST_ARM_DONE, ST_CAN_DONE,
    ST_UL0, ST_UL1, ST_UL2, ST_UL3,
    ST_LK0, ST_LK1, ST_LK2,
    ST_TICK, ST_CS0, ST_CS1, ST_CS2, ST_CS3, ST_CS4, ST_CSEND,
    ST_EX0, ST_EX1, ST_EX2, ST_EX3, ST_EX4, ST_EXEND,
    ST_RES
  } state_e;

  // Bucket that a timer with the given expiry goes to, seen from tick now.
  function automatic logic [BKT_AW-1:0] bucket_of(input logic [TICK_W-1:0] expiry,
                                                  input logic [TICK_W-1:0] now);
    logic [TICK_W-1:0] delta;
    logic [TICK_W-1:0] sh;
    logic [BKT_AW-1:0] b;
    logic              found;
    delta = expiry - now;
    b     = BKT_AW'(expiry[ROOT_BITS-1:0]);
    found = (delta < TICK_W'(ROOT_SIZE));
    for (int lv = 1; lv < LEVELS; lv++) begin
      sh = expiry >> (ROOT_BITS + (lv - 1) * LEVEL_BITS);
      if (!found && (lv == LEVELS - 1 ||
          {1'b0, delta} < (33'd1 << (ROOT_BITS + lv * LEVEL_BITS)))) begin
        b     = BKT_AW'(ROOT_SIZE + (lv - 1) * LVL_SIZE) + BKT_AW'(sh[LEVEL_BITS-1:0]);
        found = 1'b1;
      end
    end
    return b;
  endfunction

endpackage

// File: hw/rtl/htw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module htw_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/htw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer wheel front end
// Accepts commands, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module htw_front import htw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  logic [IN_W-1:0] s_tdata_i,    // timer_id[5:0], timeout[37:6]
  input  logic [OP_W-1:0] s_tuser_i,    // opcode[1:0]
  output logic            cmd_valid_o,
  output cmd_t            cmd_o,
  input  logic            cmd_pop_i
);

  cmd_t       q_mem [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] fill_q, fill_d;
  cmd_t       cls;
  logic       push;
  logic       pop;
  op_e        op;

  always_comb begin
    op          = op_e'(s_tuser_i);
    cls.id      = s_tdata_i[5:0];
    cls.timeout = s_tdata_i[37:6];
    cls.per     = (op == OP_ARM_PER);
    unique case (op)
      OP_ARM_ONE: cls.cmd = CMD_ARM;
      OP_ARM_PER: cls.cmd = (s_tdata_i[37:6] == '0) ? CMD_REFUSE : CMD_ARM;
      OP_CANCEL:  cls.cmd = CMD_CANCEL;
      OP_TICK:    cls.cmd = CMD_TICK;
      default:    cls.cmd = CMD_TICK;
    endcase
  end

  assign s_tready_o  = en_i && (fill_q != 2'd2);
  assign push        = s_tvalid_i && s_tready_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem[rptr_q];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    fill_d = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

endmodule

// File: hw/rtl/htw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer wheel engine
// Sequencer that walks the bucket lists, links and unlinks timers, cascades
// coarse levels and emits results through an output register.
// ----------------------------------------------------------------------------
module htw_engine import htw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  output logic              init_done_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [OUT_W-1:0]  m_tdata_o,
  output logic [KIND_W-1:0] m_tuser_o,
  output logic              m_tlast_o
);

  state_e state_q, state_d, ul_ret_q, ul_ret_d, lk_ret_q, lk_ret_d, rs_ret_q, rs_ret_d;
  cmd_t   cmd_q, cmd_d;

  logic [TICK_W-1:0]                   tick_q, tick_d;
  logic [LVL_NUM-1:0][LEVEL_BITS-1:0] lidx_q, lidx_d;
  logic [LVL_W-1:0]                    lvl_q, lvl_d;
  logic [MAX_TIMERS-1:0]               act_q, act_d, per_q, per_d;
  logic [CNT_W-1:0]                    cnt_q, cnt_d;
  logic [BKT_AW-1:0]                   init_q, init_d;

  logic [ID_W-1:0]   ul_id_q, ul_id_d, lk_id_q, lk_id_d, tid_q, tid_d;
  logic [LINK_W-1:0] n_q, n_d, p_q, p_d, tail_q, tail_d, cur_q, cur_d, nxt_q, nxt_d;
  logic [BKT_AW-1:0] bk_q, bk_d, lk_b_q, lk_b_d;
  logic [TICK_W-1:0] lk_exp_q, lk_exp_d;
  logic              tper_q, tper_d;

  logic              hv_q, hv_d, h_per_q, h_per_d;
  logic [ID_W-1:0]   h_id_q, h_id_d;
  logic [CNT_W-1:0]  h_cnt_q, h_cnt_d;

  kind_e             r_kind_q, r_kind_d;
  logic [ID_W-1:0]   r_id_q, r_id_d;
  logic              r_per_q, r_per_d, r_last_q, r_last_d;
  logic [CNT_W-1:0]  r_cnt_q, r_cnt_d;
  logic [TICK_W-1:0] r_now_q, r_now_d;

  logic              ov_q, ov_d, o_load;
  logic [OUT_W-1:0]  od_q, od_d;
  kind_e             ou_q, ou_d;
  logic              ol_q, ol_d;

  // memory ports
  logic              exp_we, prd_we, nx_we, pv_we, tb_we, bk_we;
  logic [ID_W-1:0]   exp_wa, prd_wa, nx_wa, pv_wa, tb_wa;
  logic [ID_W-1:0]   exp_ra, prd_ra, nx_ra, pv_ra, tb_ra;
  logic [TICK_W-1:0] exp_wd, prd_wd, exp_rd, prd_rd;
  logic [LINK_W-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
  logic [BKT_AW-1:0] tb_wd, tb_rd, bk_wa, bk_ra;
  logic [2*LINK_W-1:0] bk_wd, bk_rd;

  logic [BKT_AW-1:0] cas_addr;
  logic [BKT_AW-1:0] lk_bucket;
  logic [LINK_W-1:0] bk_head, bk_tail;

  htw_ram #(.W(TICK_W), .D(MAX_TIMERS)) u_exp (
    .clk_i, .we_i(exp_we), .waddr_i(exp_wa), .wdata_i(exp_wd), .raddr_i(exp_ra), .rdata_o(exp_rd)
  );
  htw_ram #(.W(TICK_W), .D(MAX_TIMERS)) u_prd (
    .clk_i, .we_i(prd_we), .waddr_i(prd_wa), .wdata_i(prd_wd), .raddr_i(prd_ra), .rdata_o(prd_rd)
  );
  htw_ram #(.W(LINK_W), .D(MAX_TIMERS)) u_nxt (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd), .raddr_i(nx_ra), .rdata_o(nx_rd)
  );
  htw_ram #(.W(LINK_W), .D(MAX_TIMERS)) u_prv (
    .clk_i, .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd), .raddr_i(pv_ra), .rdata_o(pv_rd)
  );
  htw_ram #(.W(BKT_AW), .D(MAX_TIMERS)) u_tbk (
    .clk_i, .we_i(tb_we), .waddr_i(tb_wa), .wdata_i(tb_wd), .raddr_i(tb_ra), .rdata_o(tb_rd)
  );
  htw_ram #(.W(2*LINK_W), .D(NBUCKETS)) u_bkt (
    .clk_i, .we_i(bk_we), .waddr_i(bk_wa), .wdata_i(bk_wd), .raddr_i(bk_ra), .rdata_o(bk_rd)
  );

  assign bk_head   = bk_rd[2*LINK_W-1:LINK_W];
  assign bk_tail   = bk_rd[LINK_W-1:0];
  assign cas_addr  = BKT_AW'(ROOT_SIZE + int'(lvl_q) * LVL_SIZE) + BKT_AW'(lidx_q[lvl_q]);
  assign lk_bucket = bucket_of(lk_exp_q, tick_q);

  assign init_done_o = (state_q != ST_INIT);
  assign m_tvalid_o  = ov_q;
  assign m_tdata_o   = od_q;
  assign m_tuser_o   = ou_q;
  assign m_tlast_o   = ol_q;

  always_comb begin
    state_d = state_q;  ul_ret_d = ul_ret_q;  lk_ret_d = lk_ret_q;  rs_ret_d = rs_ret_q;
    cmd_d = cmd_q;  tick_d = tick_q;  lidx_d = lidx_q;  lvl_d = lvl_q;
    act_d = act_q;  per_d = per_q;  cnt_d = cnt_q;  init_d = init_q;
    ul_id_d = ul_id_q;  lk_id_d = lk_id_q;  tid_d = tid_q;
    n_d = n_q;  p_d = p_q;  tail_d = tail_q;  cur_d = cur_q;  nxt_d = nxt_q;
    bk_d = bk_q;  lk_b_d = lk_b_q;  lk_exp_d = lk_exp_q;  tper_d = tper_q;
    hv_d = hv_q;  h_per_d = h_per_q;  h_id_d = h_id_q;  h_cnt_d = h_cnt_q;
    r_kind_d = r_kind_q;  r_id_d = r_id_q;  r_per_d = r_per_q;  r_last_d = r_last_q;
    r_cnt_d = r_cnt_q;  r_now_d = r_now_q;
    cmd_pop_o = 1'b0;  o_load = 1'b0;
    exp_we = 1'b0;  exp_wa = '0;  exp_wd = '0;  exp_ra = '0;
    prd_we = 1'b0;  prd_wa = '0;  prd_wd = '0;  prd_ra = '0;
    nx_we  = 1'b0;  nx_wa  = '0;  nx_wd  = '0;  nx_ra  = '0;
    pv_we  = 1'b0;  pv_wa  = '0;  pv_wd  = '0;  pv_ra  = '0;
    tb_we  = 1'b0;  tb_wa  = '0;  tb_wd  = '0;  tb_ra  = '0;
    bk_we  = 1'b0;  bk_wa  = '0;  bk_wd  = '0;  bk_ra  = '0;

    unique case (state_q)
      ST_INIT: begin
        bk_we  = 1'b1;
        bk_wa  = init_q;
        bk_wd  = {NIL, NIL};
        init_d = init_q + 1'b1;
        if (init_q == BKT_AW'(NBUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          r_id_d    = cmd_i.id;
          r_per_d   = 1'b0;
          r_last_d  = 1'b1;
          r_cnt_d   = cnt_q;
          r_now_d   = tick_q;
          rs_ret_d  = ST_IDLE;
          ul_id_d   = cmd_i.id;
          unique case (cmd_i.cmd)
            CMD_REFUSE: begin
              r_kind_d = K_REFUSED;
              state_d  = ST_RES;
            end
            CMD_ARM: begin
              ul_ret_d = ST_ARM_LINK;
              state_d  = act_q[cmd_i.id] ? ST_UL0 : ST_ARM_LINK;
            end
            CMD_CANCEL: begin
              if (act_q[cmd_i.id]) begin
                ul_ret_d = ST_CAN_DONE;
                state_d  = ST_UL0;
              end else begin
                r_kind_d = K_CANCEL_IDLE;
                state_d  = ST_RES;
              end
            end
            CMD_TICK: state_d = ST_TICK;
            default:  state_d = ST_TICK;
          endcase
        end
      end
      ST_ARM_LINK: begin
        lk_id_d  = cmd_q.id;
        lk_exp_d = tick_q + cmd_q.timeout;
        prd_we   = 1'b1;
        prd_wa   = cmd_q.id;
        prd_wd   = cmd_q.timeout;
        act_d[cmd_q.id] = 1'b1;
        per_d[cmd_q.id] = cmd_q.per;
        lk_ret_d = ST_ARM_DONE;
        state_d  = ST_LK0;
      end
      ST_ARM_DONE: begin
        r_kind_d = K_ARMED;
        r_cnt_d  = cnt_q;
        state_d  = ST_RES;
      end
      ST_CAN_DONE: begin
        act_d[cmd_q.id] = 1'b0;
        per_d[cmd_q.id] = 1'b0;
        r_kind_d = K_CANCELLED;
        r_cnt_d  = cnt_q;
        state_d  = ST_RES;
      end
      // Unlink ul_id from its bucket list.
      ST_UL0: begin
        tb_ra   = ul_id_q;
        nx_ra   = ul_id_q;
        pv_ra   = ul_id_q;
        state_d = ST_UL1;
      end
      ST_UL1: begin
        bk_d    = tb_rd;
        n_d     = nx_rd;
        p_d     = pv_rd;
        bk_ra   = tb_rd;
        state_d = ST_UL2;
      end
      ST_UL2: begin
        bk_we = 1'b1;
        bk_wa = bk_q;
        bk_wd = {(p_q[ID_W] ? n_q : bk_head), (n_q[ID_W] ? p_q : bk_tail)};
        if (!p_q[ID_W]) begin
          nx_we = 1'b1;
          nx_wa = p_q[ID_W-1:0];
          nx_wd = n_q;
        end
        state_d = ST_UL3;
      end
      ST_UL3: begin
        if (!n_q[ID_W]) begin
          pv_we = 1'b1;
          pv_wa = n_q[ID_W-1:0];
          pv_wd = p_q;
        end
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end
        state_d = ul_ret_q;
      end
      // Append lk_id with expiry lk_exp to the tail of its bucket.
      ST_LK0: begin
        lk_b_d  = lk_bucket;
        bk_ra   = lk_bucket;
        exp_we  = 1'b1;
        exp_wa  = lk_id_q;
        exp_wd  = lk_exp_q;
        state_d = ST_LK1;
      end
      ST_LK1: begin
        tail_d = bk_tail;
        tb_we  = 1'b1;
        tb_wa  = lk_id_q;
        tb_wd  = lk_b_q;
        pv_we  = 1'b1;
        pv_wa  = lk_id_q;
        pv_wd  = bk_tail;
        nx_we  = 1'b1;
        nx_wa  = lk_id_q;
        nx_wd  = NIL;
        bk_we  = 1'b1;
        bk_wa  = lk_b_q;
        bk_wd  = {(bk_tail[ID_W] ? {1'b0, lk_id_q} : bk_head), {1'b0, lk_id_q}};
        state_d = ST_LK2;
      end
      ST_LK2: begin
        if (!tail_q[ID_W]) begin
          nx_we = 1'b1;
          nx_wa = tail_q[ID_W-1:0];
          nx_wd = {1'b0, lk_id_q};
        end
        cnt_d   = cnt_q + 1'b1;
        state_d = lk_ret_q;
      end
      ST_TICK: begin
        lvl_d   = '0;
        hv_d    = 1'b0;
        state_d = (tick_q[ROOT_BITS-1:0] == '0) ? ST_CS0 : ST_EX0;
      end
      // Cascade: detach the level's current bucket and place each timer again.
      ST_CS0: begin
        bk_ra   = cas_addr;
        state_d = ST_CS1;
      end
      ST_CS1: begin
        cur_d   = bk_head;
        bk_we   = 1'b1;
        bk_wa   = cas_addr;
        bk_wd   = {NIL, NIL};
        state_d = ST_CS2;
      end
      ST_CS2: begin
        if (cur_q[ID_W]) begin
          state_d = ST_CSEND;
        end else begin
          nx_ra   = cur_q[ID_W-1:0];
          exp_ra  = cur_q[ID_W-1:0];
          state_d = ST_CS3;
        end
      end
      ST_CS3: begin
        nxt_d    = nx_rd;
        lk_exp_d = exp_rd;
        lk_id_d  = cur_q[ID_W-1:0];
        cnt_d    = cnt_q - 1'b1;   // the relink counts the timer again
        lk_ret_d = ST_CS4;
        state_d  = ST_LK0;
      end
      ST_CS4: begin
        cur_d   = nxt_q;
        state_d = ST_CS2;
      end
      ST_CSEND: begin
        lidx_d[lvl_q] = lidx_q[lvl_q] + 1'b1;
        // A level that has just left slot zero lets the next level cascade too.
        if (lidx_q[lvl_q] == '0 && lvl_q != LVL_W'(LVL_NUM - 1)) begin
          lvl_d   = lvl_q + 1'b1;
          state_d = ST_CS0;
        end else begin
          state_d = ST_EX0;
        end
      end
      // Expire the current root slot, head first.
      ST_EX0: begin
        bk_ra   = BKT_AW'(tick_q[ROOT_BITS-1:0]);
        state_d = ST_EX1;
      end
      ST_EX1: begin
        if (bk_head[ID_W]) begin
          state_d = ST_EXEND;
        end else begin
          tid_d    = bk_head[ID_W-1:0];
          ul_id_d  = bk_head[ID_W-1:0];
          tper_d   = per_q[bk_head[ID_W-1:0]];
          ul_ret_d = ST_EX2;
          state_d  = ST_UL0;
        end
      end
      ST_EX2: begin
        if (tper_q) begin
          prd_ra  = tid_q;
          state_d = ST_EX3;
        end else begin
          act_d[tid_q] = 1'b0;
          per_d[tid_q] = 1'b0;
          state_d = ST_EX4;
        end
      end
      ST_EX3: begin
        lk_exp_d = tick_q + prd_rd;
        lk_id_d  = tid_q;
        lk_ret_d = ST_EX4;
        state_d  = ST_LK0;
      end
      ST_EX4: begin
        // The previous expiry is sent once a later one shows it was not final.
        r_kind_d = K_EXPIRED;
        r_id_d   = h_id_q;
        r_per_d  = h_per_q;
        r_last_d = 1'b0;
        r_cnt_d  = h_cnt_q;
        r_now_d  = tick_q;
        rs_ret_d = ST_EX0;
        hv_d     = 1'b1;
        h_id_d   = tid_q;
        h_per_d  = tper_q;
        h_cnt_d  = cnt_q;
        state_d  = hv_q ? ST_RES : ST_EX0;
      end
      ST_EXEND: begin
        r_kind_d = hv_q ? K_EXPIRED : K_IDLE_TICK;
        r_id_d   = hv_q ? h_id_q : '0;
        r_per_d  = hv_q & h_per_q;
        r_last_d = 1'b1;
        r_cnt_d  = hv_q ? h_cnt_q : cnt_q;
        r_now_d  = tick_q;
        hv_d     = 1'b0;
        tick_d   = tick_q + 1'b1;
        rs_ret_d = ST_IDLE;
        state_d  = ST_RES;
      end
      ST_RES: begin
        if (!ov_q || m_tready_i) begin
          o_load  = 1'b1;
          state_d = rs_ret_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    od_d = od_q;
    ou_d = ou_q;
    ol_d = ol_q;
    if (o_load) begin
      ov_d = 1'b1;
      od_d = {2'b0, r_cnt_q, r_now_q, r_per_q, r_id_q};
      ou_d = r_kind_q;
      ol_d = r_last_q;
    end else if (m_tready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      ul_ret_q <= ST_IDLE;
      lk_ret_q <= ST_IDLE;
      rs_ret_q <= ST_IDLE;
      tick_q  <= '0;
      lidx_q  <= '0;
      lvl_q   <= '0;
      act_q   <= '0;
      per_q   <= '0;
      cnt_q   <= '0;
      init_q  <= '0;
      hv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ul_ret_q <= ul_ret_d;
      lk_ret_q <= lk_ret_d;
      rs_ret_q <= rs_ret_d;
      tick_q  <= tick_d;
      lidx_q  <= lidx_d;
      lvl_q   <= lvl_d;
      act_q   <= act_d;
      per_q   <= per_d;
      cnt_q   <= cnt_d;
      init_q  <= init_d;
      hv_q    <= hv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    ul_id_q  <= ul_id_d;
    lk_id_q  <= lk_id_d;
    tid_q    <= tid_d;
    n_q      <= n_d;
    p_q      <= p_d;
    tail_q   <= tail_d;
    cur_q    <= cur_d;
    nxt_q    <= nxt_d;
    bk_q     <= bk_d;
    lk_b_q   <= lk_b_d;
    lk_exp_q <= lk_exp_d;
    tper_q   <= tper_d;
    h_per_q  <= h_per_d;
    h_id_q   <= h_id_d;
    h_cnt_q  <= h_cnt_d;
    r_kind_q <= r_kind_d;
    r_id_q   <= r_id_d;
    r_per_q  <= r_per_d;
    r_last_q <= r_last_d;
    r_cnt_q  <= r_cnt_d;
    r_now_q  <= r_now_d;
    od_q     <= od_d;
    ou_q     <= ou_d;
    ol_q     <= ol_d;
  end

endmodule

// File: hw/rtl/hierarchical_timer_wheel_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hierarchical timer wheel
// Arm, cancel and tick commands in; armed, refused, cancelled, expiry and idle-tick
// results out. A command queue parts the front end from the engine.
// Each result follows the registered reads of the bucket and link RAMs that its
// command needs: an arm of an active timer unlinks it first, and a tick
// cascades the coarse levels that are due, then expires the current root slot
// and relinks its periodic timers. Commands run one at a time.
// After reset a clearing pass empties all 512 entries of the bucket RAM; no
// command is accepted until it ends.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_top import htw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [IN_W-1:0]   s_axis_tdata_i,   // timer_id[5:0], timeout[37:6]
  input  logic [OP_W-1:0]   s_axis_tuser_i,   // opcode[1:0]
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OUT_W-1:0]  m_axis_tdata_o,   // result_id[5:0], is_periodic[6],
                                              // tick_now[38:7], active_count[45:39]
  output logic [KIND_W-1:0] m_axis_tuser_o,   // kind[2:0]
  output logic              m_axis_tlast_o
);

  logic cmd_valid;
  logic cmd_pop;
  logic init_done;
  cmd_t cmd;

  htw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (init_done),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  htw_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .init_done_o (init_done),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tuser_o   (m_axis_tuser_o),
    .m_tlast_o   (m_axis_tlast_o)
  );

endmodule
